>>> src/gbd_pkg.sv
// Shared types and constants for the gray box downscaler.
// No dependencies; used by gbd_div and gray_box_downscaler.
package gbd_pkg;

    localparam int MAX_DEST_WIDTH_DEF = 1024;

    localparam int SUM_W      = 40;
    localparam int DIVIDEND_W = 40;
    localparam int DIVISOR_W  = 32;
    localparam int CNT_W      = $clog2(DIVIDEND_W + 1);

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // Configuration register indexes (paddr[3:2])
    localparam logic [1:0] REG_SRC_WIDTH  = 2'd0;
    localparam logic [1:0] REG_SRC_HEIGHT = 2'd1;
    localparam logic [1:0] REG_DST_WIDTH  = 2'd2;
    localparam logic [1:0] REG_DST_HEIGHT = 2'd3;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                  busy;
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
    } div_rsp_t;

endpackage

>>> src/gbd_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on gbd_pkg. A zero divisor gives a zero quotient.
module gbd_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  gbd_pkg::div_req_t req,
    output gbd_pkg::div_rsp_t rsp
);

    logic                            busy_reg;
    logic                            done_reg;
    logic [gbd_pkg::CNT_W-1:0]       cnt_reg;
    logic [gbd_pkg::DIVIDEND_W-1:0]  dvd_reg;
    logic [gbd_pkg::DIVISOR_W-1:0]   dvs_reg;
    logic [gbd_pkg::DIVISOR_W-1:0]   rem_reg;
    logic                            zero_reg;

    logic [gbd_pkg::DIVISOR_W:0]     rem_sh;
    logic                            ge;
    logic [gbd_pkg::DIVISOR_W-1:0]   rem_next;

    assign rem_sh   = {rem_reg, dvd_reg[gbd_pkg::DIVIDEND_W-1]};
    assign ge       = rem_sh >= {1'b0, dvs_reg};
    assign rem_next = ge ? gbd_pkg::DIVISOR_W'(rem_sh - {1'b0, dvs_reg})
                         : rem_sh[gbd_pkg::DIVISOR_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= gbd_pkg::CNT_W'(gbd_pkg::DIVIDEND_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == gbd_pkg::CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg  <= req.dividend;
            dvs_reg  <= req.divisor;
            rem_reg  <= '0;
            zero_reg <= (req.divisor == '0);
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[gbd_pkg::DIVIDEND_W-2:0], ge};
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = zero_reg ? '0 : dvd_reg;

endmodule

>>> src/gray_box_downscaler.sv
// Channel   | signals                                  | direction
// ----------+------------------------------------------+----------
// input     | in_valid, in_stall, pixel                | into block
// output    | out_valid, out_stall, value, dest_x,     | out of block
//           | dest_y, frame_last                       |
// config    | APB: psel penable pwrite paddr pwdata    | into block
//           |      prdata pready                       |
//
// Steps: an item that closes no box and no box boundary is accepted, then
// its column sum is read, modified and written. Closing a box adds a launch,
// the area divide and the output load, and waits while the output register
// stays full; crossing a column or band boundary adds a boundary divide. The
// shared 40-step divider does every divide.
// A register write is followed by working out the first column and row
// boundaries; in_stall is high meanwhile.
// Reset clears all control state; column sums need none, since the first
// row of each band writes its sum before any row reads it.
// A stalled output holds its result; the block waits only when it has a new
// result to place, and starts any owed boundary divide after placing it.
// Depends on gbd_pkg and gbd_div.
module gray_box_downscaler
#(
    parameter int MAX_DEST_WIDTH = gbd_pkg::MAX_DEST_WIDTH_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    // input channel
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [7:0]                  pixel,
    // output channel
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [7:0]                  value,
    output logic [9:0]                  dest_x,
    output logic [15:0]                 dest_y,
    output logic                        frame_last,
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [gbd_pkg::PADDR_W-1:0] paddr,
    input  logic [gbd_pkg::PDATA_W-1:0] pwdata,
    output logic [gbd_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);

    localparam int AW = (MAX_DEST_WIDTH > 1) ? $clog2(MAX_DEST_WIDTH) : 1;

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_RMW     = 8'b0000_0010,  // sum read data is back: modify, write
        S_AVG_GO  = 8'b0000_0100,  // launch sum / area
        S_AVG_WT  = 8'b0000_1000,
        S_OUT     = 8'b0001_0000,  // place result into output register
        S_BND_WT  = 8'b0010_0000,  // next column or band boundary
        S_CFG_GO  = 8'b0100_0000,  // first boundaries after a write
        S_CFGC_WT = 8'b1000_0000
    } state_t;

    // first-row boundary divide reuses S_BND_WT with bnd_row set
    state_t state_reg, state_next;

    // configuration
    logic [15:0] src_width_reg, src_height_reg, dst_height_reg;
    logic [10:0] dst_width_reg;

    // frame position
    logic [15:0]   source_col_reg, source_row_reg, dest_row_reg;
    logic [AW-1:0] dest_col_reg;
    logic [15:0]   box_col_start_reg, band_row_start_reg;
    logic [16:0]   box_col_end_reg, band_row_end_reg;
    logic [16:0]   first_col_end_reg, first_row_end_reg;

    // per-item work
    logic [7:0]                      pix_reg;
    logic [gbd_pkg::SUM_W-1:0]       sum_reg;
    logic [gbd_pkg::DIVISOR_W-1:0]   area_reg;
    logic [gbd_pkg::DIVIDEND_W-1:0]  bnd_prod_reg;
    logic                            bnd_pend_reg;  // boundary divide owed
    logic                            bnd_row_reg;   // 1: band row, 0: column
    logic                            cfg_first_reg; // boundary is first one
    logic [9:0]                      pend_x_reg;
    logic [15:0]                     pend_y_reg;
    logic                            pend_last_reg;

    // output register
    logic        out_valid_reg;
    logic [7:0]  value_reg;
    logic [9:0]  dest_x_reg;
    logic [15:0] dest_y_reg;
    logic        frame_last_reg;

    // column sum memory
    logic [gbd_pkg::SUM_W-1:0] sums_mem [MAX_DEST_WIDTH];
    logic [gbd_pkg::SUM_W-1:0] mem_q_reg;

    gbd_pkg::div_req_t div_req;
    gbd_pkg::div_rsp_t div_rsp;

    gbd_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // ------------------------------------------------------------------
    // Config port
    // ------------------------------------------------------------------
    logic       cfg_wr;
    logic [1:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[3:2];

    always_comb
    begin
        case (cfg_idx)
            gbd_pkg::REG_SRC_WIDTH:  prdata = {16'd0, src_width_reg};
            gbd_pkg::REG_SRC_HEIGHT: prdata = {16'd0, src_height_reg};
            gbd_pkg::REG_DST_WIDTH:  prdata = {21'd0, dst_width_reg};
            gbd_pkg::REG_DST_HEIGHT: prdata = {16'd0, dst_height_reg};
            default:                 prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Item decode
    // ------------------------------------------------------------------
    logic enabled;
    logic in_acc;
    logic col_last, row_last, row_end, frame_end;
    logic [gbd_pkg::SUM_W-1:0] sum_new;
    logic [16:0] bnd_i;
    logic [gbd_pkg::DIVIDEND_W-1:0] bnd_prod;
    logic        out_load;

    assign enabled = (src_width_reg != '0) && (src_height_reg != '0) &&
                     (dst_width_reg != '0) && (dst_height_reg != '0) &&
                     ({5'd0, dst_width_reg} <= src_width_reg) &&
                     (dst_height_reg <= src_height_reg) &&
                     (32'(dst_width_reg) <= 32'(MAX_DEST_WIDTH));

    assign in_stall = (state_reg != S_IDLE);
    assign in_acc   = in_valid && !in_stall;

    assign col_last  = ({1'b0, source_col_reg} + 17'd1) == box_col_end_reg;
    assign row_last  = ({1'b0, source_row_reg} + 17'd1) == band_row_end_reg;
    assign row_end   = ({1'b0, source_col_reg} + 17'd1) >= {1'b0, src_width_reg};
    assign frame_end = row_end &&
                       (({1'b0, source_row_reg} + 17'd1) >= {1'b0, src_height_reg});

    // first row of a band overwrites, so unwritten entries are never read
    assign sum_new = (source_row_reg == band_row_start_reg) ? {32'd0, pix_reg}
                   : gbd_pkg::SUM_W'(mem_q_reg + {32'd0, pix_reg});

    // index of the boundary after the one being crossed
    assign bnd_i = row_end ? (17'(dest_row_reg) + 17'd2) : (17'(dest_col_reg) + 17'd2);

    assign bnd_prod = gbd_pkg::DIVIDEND_W'(bnd_i) *
                      gbd_pkg::DIVIDEND_W'(row_end ? src_height_reg : src_width_reg);

    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || !out_stall);

    // ------------------------------------------------------------------
    // Divider requests
    // ------------------------------------------------------------------
    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = bnd_prod_reg;
        div_req.divisor  = bnd_row_reg ? {16'd0, dst_height_reg}
                                       : {21'd0, dst_width_reg};
        case (state_reg)
            S_RMW:
            begin
                // column boundary crossed inside a band row with no result
                div_req.start    = col_last && !row_last && !row_end;
                div_req.dividend = bnd_prod;
                div_req.divisor  = {21'd0, dst_width_reg};
            end
            S_AVG_GO:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = sum_reg;
                div_req.divisor  = area_reg;
            end
            S_OUT:     div_req.start = out_load && bnd_pend_reg;
            S_CFG_GO:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = {24'd0, src_width_reg};
                div_req.divisor  = {21'd0, dst_width_reg};
            end
            S_CFGC_WT:
            begin
                div_req.start    = div_rsp.done;
                div_req.dividend = {24'd0, src_height_reg};
                div_req.divisor  = {16'd0, dst_height_reg};
            end
            default:   div_req.start = 1'b0;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:    if (in_acc && enabled) state_next = S_RMW;
            S_RMW:
            begin
                if (col_last && row_last)
                    state_next = S_AVG_GO;
                else if (!frame_end && ((row_end && row_last) ||
                                        (!row_end && col_last)))
                    state_next = S_BND_WT;
                else
                    state_next = S_IDLE;
            end
            S_AVG_GO:  state_next = S_AVG_WT;
            S_AVG_WT:  if (div_rsp.done) state_next = S_OUT;
            S_OUT:     if (out_load) state_next = bnd_pend_reg ? S_BND_WT : S_IDLE;
            S_BND_WT:  if (div_rsp.done) state_next = S_IDLE;
            S_CFG_GO:  state_next = S_CFGC_WT;
            S_CFGC_WT: if (div_rsp.done) state_next = S_BND_WT;
            default:   state_next = S_IDLE;
        endcase
        if (cfg_wr)
            state_next = S_CFG_GO;
    end

    // RMW on a single entry: the write lands at the end of S_RMW and the
    // next read is issued no earlier than the following S_IDLE cycle.
    always_ff @(posedge clk)
    begin
        if (in_acc)
            mem_q_reg <= sums_mem[dest_col_reg];
        if (state_reg == S_RMW)
            sums_mem[dest_col_reg] <= sum_new;
    end

    // per-item payload
    always_ff @(posedge clk)
    begin
        if (in_acc)
            pix_reg <= pixel;
        if (state_reg == S_RMW)
        begin
            sum_reg       <= sum_new;
            area_reg      <= gbd_pkg::DIVISOR_W'(
                                 gbd_pkg::DIVISOR_W'(box_col_end_reg -
                                                     {1'b0, box_col_start_reg}) *
                                 gbd_pkg::DIVISOR_W'(band_row_end_reg -
                                                     {1'b0, band_row_start_reg}));
            bnd_prod_reg  <= bnd_prod;
            pend_x_reg    <= 10'(dest_col_reg);
            pend_y_reg    <= dest_row_reg;
            pend_last_reg <= frame_end;
        end
        if (out_load)
        begin
            value_reg      <= div_rsp.quotient[7:0];
            dest_x_reg     <= pend_x_reg;
            dest_y_reg     <= pend_y_reg;
            frame_last_reg <= pend_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            src_width_reg      <= '0;
            src_height_reg     <= '0;
            dst_width_reg      <= '0;
            dst_height_reg     <= '0;
            source_col_reg     <= '0;
            source_row_reg     <= '0;
            dest_col_reg       <= '0;
            dest_row_reg       <= '0;
            box_col_start_reg  <= '0;
            band_row_start_reg <= '0;
            box_col_end_reg    <= '0;
            band_row_end_reg   <= '0;
            first_col_end_reg  <= '0;
            first_row_end_reg  <= '0;
            bnd_pend_reg       <= 1'b0;
            bnd_row_reg        <= 1'b0;
            cfg_first_reg      <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            if (out_load)
                bnd_pend_reg <= 1'b0;

            if (state_reg == S_RMW)
            begin
                bnd_pend_reg  <= 1'b0;
                cfg_first_reg <= 1'b0;
                if (frame_end)
                begin
                    source_col_reg     <= '0;
                    dest_col_reg       <= '0;
                    box_col_start_reg  <= '0;
                    box_col_end_reg    <= first_col_end_reg;
                    source_row_reg     <= '0;
                    dest_row_reg       <= '0;
                    band_row_start_reg <= '0;
                    band_row_end_reg   <= first_row_end_reg;
                end
                else if (row_end)
                begin
                    source_col_reg    <= '0;
                    dest_col_reg      <= '0;
                    box_col_start_reg <= '0;
                    box_col_end_reg   <= first_col_end_reg;
                    source_row_reg    <= source_row_reg + 16'd1;
                    if (row_last)
                    begin
                        dest_row_reg       <= dest_row_reg + 16'd1;
                        band_row_start_reg <= band_row_end_reg[15:0];
                        bnd_pend_reg       <= col_last;
                        bnd_row_reg        <= 1'b1;
                    end
                end
                else
                begin
                    source_col_reg <= source_col_reg + 16'd1;
                    if (col_last)
                    begin
                        dest_col_reg      <= dest_col_reg + 1'b1;
                        box_col_start_reg <= box_col_end_reg[15:0];
                        bnd_pend_reg      <= row_last;
                        bnd_row_reg       <= 1'b0;
                    end
                end
            end

            // first column boundary, then launch the first row boundary
            if (state_reg == S_CFGC_WT && div_rsp.done)
            begin
                first_col_end_reg <= div_rsp.quotient[16:0];
                box_col_end_reg   <= div_rsp.quotient[16:0];
                bnd_row_reg       <= 1'b1;
                cfg_first_reg     <= 1'b1;
            end

            if (state_reg == S_BND_WT && div_rsp.done)
            begin
                if (bnd_row_reg)
                    band_row_end_reg <= div_rsp.quotient[16:0];
                else
                    box_col_end_reg <= div_rsp.quotient[16:0];
                if (cfg_first_reg)
                    first_row_end_reg <= div_rsp.quotient[16:0];
                cfg_first_reg <= 1'b0;
            end

            if (cfg_wr)
            begin
                case (cfg_idx)
                    gbd_pkg::REG_SRC_WIDTH:  src_width_reg  <= pwdata[15:0];
                    gbd_pkg::REG_SRC_HEIGHT: src_height_reg <= pwdata[15:0];
                    gbd_pkg::REG_DST_WIDTH:  dst_width_reg  <= pwdata[10:0];
                    gbd_pkg::REG_DST_HEIGHT: dst_height_reg <= pwdata[15:0];
                    default:                 src_width_reg  <= src_width_reg;
                endcase
                source_col_reg     <= '0;
                source_row_reg     <= '0;
                dest_col_reg       <= '0;
                dest_row_reg       <= '0;
                box_col_start_reg  <= '0;
                band_row_start_reg <= '0;
                bnd_pend_reg       <= 1'b0;
                bnd_row_reg        <= 1'b0;
                cfg_first_reg      <= 1'b0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign value      = value_reg;
    assign dest_x     = dest_x_reg;
    assign dest_y     = dest_y_reg;
    assign frame_last = frame_last_reg;

endmodule

>>> src/gbd_chk.sv
// Port-level checker for the gray box downscaler, bound to the top level.
// Depends on gray_box_downscaler.
module gbd_chk
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [7:0]  value,
    input logic [9:0]  dest_x,
    input logic [15:0] dest_y,
    input logic        frame_last,
    input logic        psel,
    input logic        penable,
    input logic        pwrite
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(value) &&
        $stable(dest_x) && $stable(dest_y) && $stable(frame_last))
        else $error("stalled output changed");

    // a stalled item stays offered
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid)
        else $error("stalled item withdrawn");

    // a register write blocks items while boundaries are recomputed
    a_cfg_stall: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite |=> in_stall ##1 in_stall)
        else $error("item taken during boundary setup");

    // a result appears only out of item processing
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall) && $past(in_stall, 2))
        else $error("result without item in flight");

endmodule

bind gray_box_downscaler gbd_chk u_gbd_chk
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .value      (value),
    .dest_x     (dest_x),
    .dest_y     (dest_y),
    .frame_last (frame_last),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite)
);
